>>> hw/rtl/prb_pkg.sv
package prb_pkg;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_TAKE   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_TAKEN     = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] seq_number;
      logic [15:0] length;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_seq;
      logic [15:0] out_length;
      logic [15:0] min_seq;
      logic [4:0]  held_count;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_TAKE,
      FSM_LINK,
      FSM_DONE
   } fsm_type;

   // a is ahead of b in 16-bit wraparound order
   function automatic logic seq_greater(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      begin
         d = a - b;
         seq_greater = (d != 16'd0) && !d[15];
      end
   endfunction

endpackage

>>> hw/rtl/prb_store.sv
// Slot memory: sequence, length and both links share one address per read.
module prb_store import prb_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_seq,
   output logic [15:0]   rd_len,
   output logic [AW-1:0] rd_next,
   output logic [AW-1:0] rd_prev,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_seq,
   input  logic [15:0]   wr_len,
   input  logic [AW-1:0] wr_next,
   input  logic [AW-1:0] wr_prev
);

   logic [15:0]   seq_mem  [DEPTH];
   logic [15:0]   len_mem  [DEPTH];
   logic [AW-1:0] next_mem [DEPTH];
   logic [AW-1:0] prev_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[wr_addr]  <= wr_seq;
         len_mem[wr_addr]  <= wr_len;
         next_mem[wr_addr] <= wr_next;
         prev_mem[wr_addr] <= wr_prev;
      end
      if (rd_en) begin
         rd_seq  <= seq_mem[rd_addr];
         rd_len  <= len_mem[rd_addr];
         rd_next <= next_mem[rd_addr];
         rd_prev <= prev_mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/packet_resequencing_buffer.sv
// Packet resequencing buffer.
// req_ channel carries one command word: insert (seq_number, length) or
// take out the smallest entry. rsp_ returns one word per command: status,
// entry taken out, current minimum and count held.
// csr_ writes capacity (0 acts as 1, above DEPTH as DEPTH) and empties the
// buffer; csr_ready is high only while idle, and a pending write holds off req_.
// Entries live in a slot memory with a registered read. Insert walks
// the sorted list from the tail, one memory read per entry visited, then
// links the new slot, with one more neighbour to patch when it lands
// between two entries; into an empty list it only writes the new slot.
// Take-out reads the head and, unless it empties the list, its successor.
// Full and empty answer without a memory read, a duplicate once the walk
// finds the matching entry.
// One command is worked at a time; req_ready is high only while idle. The
// result sits in an output register, and req_ready returns as soon as it
// is taken, so a stalled receiver holds the block.
// Reset empties the list and sets capacity to 16 (or DEPTH if smaller).
// The free pool is a counter over never-used slots plus a LIFO chain of
// freed slots, so the memory needs no clearing pass.
module packet_resequencing_buffer import prb_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [4:0] CAP_RESET = (DEPTH < 16) ? 5'(DEPTH) : 5'd16;

   fsm_type       state_ff, state_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] fresh_ff, fresh_in;   // slots never used yet
   logic [AW-1:0] free_head_ff, free_head_in;
   logic [CW-1:0] chain_ff, chain_in;   // freed slots on the chain
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] held_ff, held_in;
   logic [15:0]   min_ff, min_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [1:0]    step_ff, step_in;
   logic          at_head_ff, at_head_in;   // insert becomes new head
   logic [AW-1:0] after_ff, after_in;        // slot to link after
   logic [AW-1:0] nx_ff, nx_in;              // successor of after slot
   logic [AW-1:0] new_ff, new_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_seq, rd_len;
   logic [AW-1:0] rd_next, rd_prev;
   logic          wr_en;
   logic [AW-1:0] wr_addr, wr_next, wr_prev;
   logic [15:0]   wr_seq, wr_len;
   logic          rd_pend_ff, rd_pend_in;

   logic [4:0]    cap_clip;
   logic [CW-1:0] free_total;

   prb_store #(.DEPTH(DEPTH)) u_store (
      .clock, .rd_en, .rd_addr, .rd_seq, .rd_len, .rd_next, .rd_prev,
      .wr_en, .wr_addr, .wr_seq, .wr_len, .wr_next, .wr_prev
   );

   assign req_ready = (state_ff == FSM_IDLE) && !rsp_valid_ff && !csr_valid;
   assign csr_ready = (state_ff == FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign free_total = cap_ff - held_ff;

   always_comb begin
      cap_clip = csr_data;
      if (cap_clip == 5'd0) cap_clip = 5'd1;
      if (32'(cap_clip) > DEPTH) cap_clip = 5'(DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cap_ff       <= CW'(CAP_RESET);
         fresh_ff     <= '0;
         free_head_ff <= '0;
         chain_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fresh_ff     <= fresh_in;
         free_head_ff <= free_head_in;
         chain_ff     <= chain_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
      walk_ff    <= walk_in;
      cur_ff     <= cur_in;
      step_ff    <= step_in;
      at_head_ff <= at_head_in;
      after_ff   <= after_in;
      nx_ff      <= nx_in;
      new_ff     <= new_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      fresh_in     = fresh_ff;
      free_head_in = free_head_ff;
      chain_in     = chain_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      held_in      = held_ff;
      min_in       = min_ff;
      walk_in      = walk_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      at_head_in   = at_head_ff;
      after_in     = after_ff;
      nx_in        = nx_ff;
      new_in       = new_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_pend_in   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = new_ff;
      wr_seq       = req_ff.seq_number;
      wr_len       = req_ff.length;
      wr_next      = '0;
      wr_prev      = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (csr_valid) begin
               cap_in   = CW'(cap_clip);
               fresh_in = '0;
               chain_in = '0;
               head_in  = '0;
               tail_in  = '0;
               held_in  = '0;
               min_in   = '0;
            end else if (req_valid && req_ready) begin
               req_in          = req_data;
               rsp_in.out_seq    = '0;
               rsp_in.out_length = '0;
               if (req_data.command == CMD_INSERT) begin
                  if (free_total == '0) begin
                     rsp_in.status = ST_FULL;
                     state_in      = FSM_DONE;
                  end else if (held_ff == '0) begin
                     at_head_in = 1'b1;
                     state_in   = FSM_LINK;
                     step_in    = 2'd0;
                  end else begin
                     // start at the tail and walk towards the head
                     rd_en      = 1'b1;
                     rd_addr    = tail_ff;
                     cur_in     = tail_ff;
                     rd_pend_in = 1'b1;
                     walk_in    = held_ff;
                     state_in   = FSM_WALK;
                  end
                  // pick the new slot: chain first, then never-used slots
                  if (chain_ff != '0) begin
                     new_in = free_head_ff;
                  end else begin
                     new_in = AW'(fresh_ff);
                  end
               end else begin
                  if (held_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                     state_in      = FSM_DONE;
                  end else begin
                     rd_en      = 1'b1;
                     rd_addr    = head_ff;
                     cur_in     = head_ff;
                     rd_pend_in = 1'b1;
                     step_in    = 2'd0;
                     state_in   = FSM_TAKE;
                  end
               end
            end
         end
         FSM_WALK: begin
            if (rd_pend_ff) begin
               if (seq_greater(req_ff.seq_number, rd_seq)) begin
                  at_head_in = 1'b0;
                  after_in   = cur_ff;
                  nx_in      = rd_next;
                  step_in    = 2'd0;
                  state_in   = FSM_LINK;
               end else if (req_ff.seq_number == rd_seq) begin
                  rsp_in.status = ST_DUPLICATE;
                  state_in      = FSM_DONE;
               end else if (walk_ff == CW'(1)) begin
                  at_head_in = 1'b1;
                  step_in    = 2'd0;
                  state_in   = FSM_LINK;
               end else begin
                  walk_in    = walk_ff - CW'(1);
                  rd_en      = 1'b1;
                  rd_addr    = rd_prev;
                  cur_in     = rd_prev;
                  rd_pend_in = 1'b1;
               end
            end
         end
         FSM_LINK: begin
            // step 0: read the free chain link if the slot comes from it
            // step 1: write the new slot, step 2: patch neighbours
            case (step_ff)
               2'd0: begin
                  if (chain_ff != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = new_ff;
                  end
                  step_in = 2'd1;
               end
               2'd1: begin
                  if (chain_ff != '0) begin
                     free_head_in = rd_next;
                     chain_in     = chain_ff - CW'(1);
                  end else begin
                     fresh_in = fresh_ff + CW'(1);
                  end
                  wr_en   = 1'b1;
                  wr_addr = new_ff;
                  if (at_head_ff) begin
                     wr_prev = '0;
                     wr_next = head_ff;
                     min_in  = req_ff.seq_number;
                     head_in = new_ff;
                     if (held_ff == '0) begin
                        wr_next = '0;
                        tail_in = new_ff;
                        step_in = 2'd3;
                     end else begin
                        // old head needs its prev; read it for the rewrite
                        rd_en   = 1'b1;
                        rd_addr = head_ff;
                        cur_in  = head_ff;
                        step_in = 2'd2;
                     end
                  end else begin
                     wr_prev = after_ff;
                     wr_next = (after_ff == tail_ff) ? new_ff : nx_ff;
                     if (after_ff == tail_ff) begin
                        wr_next = '0;
                        tail_in = new_ff;
                     end
                     rd_en   = 1'b1;
                     rd_addr = after_ff;
                     cur_in  = after_ff;
                     step_in = 2'd2;
                  end
                  held_in = held_ff + CW'(1);
               end
               2'd2: begin
                  // read issued last step; patch this neighbour
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_seq  = rd_seq;
                  wr_len  = rd_len;
                  wr_next = rd_next;
                  wr_prev = rd_prev;
                  if (at_head_ff) begin
                     wr_prev = new_ff;
                     step_in = 2'd3;
                  end else begin
                     wr_next = new_ff;
                     if (cur_ff == after_ff && new_ff != tail_ff) begin
                        // then fix the successor's prev
                        rd_en   = 1'b1;
                        rd_addr = nx_ff;
                        cur_in  = nx_ff;
                        after_in = new_ff;
                        step_in = 2'd2;
                        at_head_in = 1'b1;
                        new_in  = new_ff;
                     end else begin
                        step_in = 2'd3;
                     end
                  end
               end
               default: begin
                  rsp_in.status = ST_INSERTED;
                  state_in      = FSM_DONE;
               end
            endcase
         end
         FSM_TAKE: begin
            case (step_ff)
               2'd0: begin
                  rsp_in.out_seq    = rd_seq;
                  rsp_in.out_length = rd_len;
                  nx_in             = rd_next;
                  // push the slot onto the free chain
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_seq  = rd_seq;
                  wr_len  = rd_len;
                  wr_next = free_head_ff;
                  wr_prev = '0;
                  free_head_in = cur_ff;
                  chain_in     = chain_ff + CW'(1);
                  held_in      = held_ff - CW'(1);
                  if (held_ff == CW'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                     rsp_in.status = ST_TAKEN;
                     state_in      = FSM_DONE;
                  end else begin
                     head_in = rd_next;
                     rd_en   = 1'b1;
                     rd_addr = rd_next;
                     cur_in  = rd_next;
                     step_in = 2'd1;
                  end
               end
               default: begin
                  min_in  = rd_seq;
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_seq  = rd_seq;
                  wr_len  = rd_len;
                  wr_next = rd_next;
                  wr_prev = '0;
                  rsp_in.status = ST_TAKEN;
                  state_in      = FSM_DONE;
               end
            endcase
         end
         FSM_DONE: begin
            rsp_in.min_seq    = min_ff;
            rsp_in.held_count = 5'(held_ff);
            rsp_valid_in      = 1'b1;
            state_in          = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff) else $error("held count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == FSM_IDLE) else $error("ready outside idle");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == FSM_DONE)
      else $error("result without completion");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != FSM_IDLE |=> (held_ff == $past(held_ff) ||
      held_ff == $past(held_ff) + CW'(1) || held_ff == $past(held_ff) - CW'(1)))
      else $error("held count jumped");
`endif

endmodule
